// ===== hw/rtl/ps2mct_pkg.sv =====
package ps2mct_pkg;

  localparam int unsigned CFG_W          = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned BTN_W          = 3;
  localparam int unsigned DX_W           = 8;
  localparam int unsigned DY_W           = 9;
  localparam int unsigned SYNC_BIT       = 3;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd768;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  typedef struct packed {
    logic                    done;
    logic [BTN_W-1:0]        buttons;
    logic signed [DX_W-1:0]  delta_x;
    logic signed [DY_W-1:0]  delta_y;
  } pkt_t;

endpackage

// ===== hw/rtl/ps2mct_assembler.sv =====
module ps2mct_assembler
  import ps2mct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output pkt_t       pkt_o
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_X,
    PH_Y
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    pkt_o.done    = 1'b0;
    pkt_o.buttons = first_q[BTN_W-1:0];
    pkt_o.delta_x = $signed(second_q);
    pkt_o.delta_y = -$signed({byte_i[7], byte_i});
    if (step_i) begin
      unique case (phase_q)
        PH_FIRST: begin
          first_d = byte_i;
          if (byte_i[SYNC_BIT]) begin
            phase_d = PH_X;
          end
        end
        PH_X: begin
          second_d = byte_i;
          phase_d  = PH_Y;
        end
        PH_Y: begin
          phase_d    = PH_FIRST;
          pkt_o.done = 1'b1;
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FIRST;
      first_q  <= '0;
      second_q <= '0;
    end else begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

// ===== hw/rtl/ps2mct_cursor.sv =====
module ps2mct_cursor
  import ps2mct_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   upd_i,
  input  logic signed [DY_W-1:0] delta_i,
  input  logic [CFG_W-1:0]       bound_i,
  output logic [COORD_BITS-1:0]  pos_d_o
);

  localparam int unsigned LW = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  localparam int unsigned SW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] pos_q;
  logic [LW-1:0]         bound_ext;
  logic [LW-1:0]         cap;
  logic [LW-1:0]         eff;
  logic [LW-1:0]         eff_m1;
  logic [COORD_BITS-1:0] lim;
  logic signed [SW-1:0]  sum;

  always_comb begin
    bound_ext = LW'(bound_i);
    cap       = LW'(1) << COORD_BITS;
    if (bound_ext == '0) begin
      eff = LW'(1);
    end else if (bound_ext > cap) begin
      eff = cap;
    end else begin
      eff = bound_ext;
    end
    eff_m1 = eff - LW'(1);
    lim    = eff_m1[COORD_BITS-1:0];
    sum    = $signed({2'b00, pos_q}) + SW'(delta_i);
    if (sum < 0) begin
      pos_d_o = '0;
    end else if (sum > $signed({2'b00, lim})) begin
      pos_d_o = lim;
    end else begin
      pos_d_o = sum[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (upd_i) begin
      pos_q <= pos_d_o;
    end
  end

endmodule

// ===== hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv =====
// PS/2 mouse packet decoder with a clamped cursor.
// The input channel carries one received mouse byte per beat. The block
// synchronises on a first byte with bit 3 set, then takes the X and Y delta
// bytes; the third byte of a packet yields one result beat with the buttons,
// the signed deltas (Y negated so that down is positive) and the cursor
// position, clamped to the screen bounds held in two configuration registers.
// A byte that completes no packet yields no result.
// An accepted byte is registered in the input register and its result in the output register.
// Throughput is one byte per cycle unless the receiver stalls; the input
// register and the output register form a two-stage pipeline with one adder and clamp per axis.
// Reset clears the packet phase and the cursor to zero and loads the bounds
// with 1024 and 768. While the receiver stalls, the result beat is held, and at
// most one more byte enters the input register before in_stall_o rises.
// Configuration writes are taken in any cycle and should be made only while
// the block is idle.
module ps2_mouse_packet_cursor_tracker_top
  import ps2mct_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BTN_W-1:0]       buttons_o,
  output logic signed [DX_W-1:0] delta_x_o,
  output logic signed [DY_W-1:0] delta_y_o,
  output logic [COORD_BITS-1:0]  cursor_x_o,
  output logic [COORD_BITS-1:0]  cursor_y_o
);

  logic [CFG_W-1:0]      width_q;
  logic [CFG_W-1:0]      height_q;
  logic                  in_vld_q;
  logic [7:0]            in_byte_q;
  logic                  out_hold;
  logic                  step;
  pkt_t                  pkt;
  logic [COORD_BITS-1:0] pos_x_d;
  logic [COORD_BITS-1:0] pos_y_d;
  logic                  out_vld_q;
  logic [BTN_W-1:0]      buttons_q;
  logic signed [DX_W-1:0] delta_x_q;
  logic signed [DY_W-1:0] delta_y_q;
  logic [COORD_BITS-1:0] cursor_x_q;
  logic [COORD_BITS-1:0] cursor_y_q;

  assign out_hold   = out_vld_q & out_stall_i;
  assign in_stall_o = in_vld_q & out_hold;
  assign step       = in_vld_q & ~out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ps2mct_assembler u_assembler (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .pkt_o  (pkt)
  );

  ps2mct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (pkt.done),
    .delta_i (DY_W'(pkt.delta_x)),
    .bound_i (width_q),
    .pos_d_o (pos_x_d)
  );

  ps2mct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (pkt.done),
    .delta_i (pkt.delta_y),
    .bound_i (height_q),
    .pos_d_o (pos_y_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_hold) begin
      out_vld_q <= pkt.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt.done) begin
      buttons_q  <= pkt.buttons;
      delta_x_q  <= pkt.delta_x;
      delta_y_q  <= pkt.delta_y;
      cursor_x_q <= pos_x_d;
      cursor_y_q <= pos_y_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign buttons_o   = buttons_q;
  assign delta_x_o   = delta_x_q;
  assign delta_y_o   = delta_y_q;
  assign cursor_x_o  = cursor_x_q;
  assign cursor_y_o  = cursor_y_q;

endmodule

// ===== hw/rtl/ps2mct_checker.sv =====
module ps2mct_checker
  import ps2mct_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [DY_W-1:0] delta_y_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result beat was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled without a stalled result beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("Result beat appeared without a byte accepted two cycles earlier.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delta_y_o[DY_W-1] |-> delta_y_o[DY_W-2:0] != '0)
    else $error("Negated Y delta outside its range.");

endmodule

bind ps2_mouse_packet_cursor_tracker_top ps2mct_checker u_ps2mct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .delta_y_o   (delta_y_o)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ps2mct_pkg::*;

  localparam int COORD_W  = COORD_BITS_DEF;
  localparam int PIPE_LAT = 2;
  localparam int PHASE_ITEMS = 180;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {AWAIT_HDR, AWAIT_X, AWAIT_Y} pkt_phase_e;

  typedef struct packed {
    logic [BTN_W-1:0]       buttons;
    logic signed [DX_W-1:0] delta_x;
    logic signed [DY_W-1:0] delta_y;
    logic [COORD_W-1:0]     cursor_x;
    logic [COORD_W-1:0]     cursor_y;
  } motion_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             rx_byte_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [BTN_W-1:0]       buttons_o;
  logic signed [DX_W-1:0] delta_x_o;
  logic signed [DY_W-1:0] delta_y_o;
  logic [COORD_W-1:0]     cursor_x_o;
  logic [COORD_W-1:0]     cursor_y_o;

  ps2_mouse_packet_cursor_tracker_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .buttons_o   (buttons_o),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o),
    .cursor_x_o  (cursor_x_o),
    .cursor_y_o  (cursor_y_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Tracker state kept alongside the block.
  pkt_phase_e         pkt_phase = AWAIT_HDR;
  logic [7:0]         hdr_byte  = '0;
  logic [7:0]         x_byte    = '0;
  logic [COORD_W-1:0] cur_x     = '0;
  logic [COORD_W-1:0] cur_y     = '0;
  logic [CFG_W-1:0]   bound_w   = WIDTH_RST;
  logic [CFG_W-1:0]   bound_h   = HEIGHT_RST;

  logic [7:0] byte_q[$];
  motion_t    motion_q[$];

  bit in_took, out_took;
  bit in_burst, out_burst;
  int in_wait, out_hold;
  int bytes_in, packets_seen, clamp_hits, settings_used;
  int mismatches, failures;

  function automatic logic [COORD_W-1:0] clamp_axis(input int pos, input int delta,
                                                    input logic [CFG_W-1:0] bound);
    int lim;
    int v;
    if (bound == 0) lim = 0;
    else if (bound > (1 << COORD_W)) lim = (1 << COORD_W) - 1;
    else lim = int'(bound) - 1;
    v = pos + delta;
    if (v < 0) begin
      v = 0;
      clamp_hits++;
    end
    if (v > lim) begin
      v = lim;
      clamp_hits++;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output motion_t m);
    int dx;
    int dy;
    m = '0;
    case (pkt_phase)
      AWAIT_HDR: begin
        hdr_byte = b;
        if (b[SYNC_BIT]) pkt_phase = AWAIT_X;
        return 1'b0;
      end
      AWAIT_X: begin
        x_byte = b;
        pkt_phase = AWAIT_Y;
        return 1'b0;
      end
      AWAIT_Y: begin
        pkt_phase = AWAIT_HDR;
        dx = int'($signed(x_byte));
        dy = -int'($signed(b));
        cur_x = clamp_axis(int'(cur_x), dx, bound_w);
        cur_y = clamp_axis(int'(cur_y), dy, bound_h);
        m.buttons  = hdr_byte[BTN_W-1:0];
        m.delta_x  = dx[DX_W-1:0];
        m.delta_y  = dy[DY_W-1:0];
        m.cursor_x = cur_x;
        m.cursor_y = cur_y;
        return 1'b1;
      end
      default: begin
        pkt_phase = AWAIT_HDR;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [7:0] delta_byte(input int drift);
    if (drift != 0 && $urandom_range(0, 1) == 1) begin
      if (drift > 0) return 8'($urandom_range(8'h40, 8'h7F));
      return 8'($urandom_range(8'h80, 8'hC0));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SCREEN_WIDTH:  bound_w = val;
      REG_SCREEN_HEIGHT: bound_h = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || motion_q.size() != 0);
    repeat (PIPE_LAT + 3) @(negedge clk_i);
  endtask

  task automatic check_motion();
    motion_t exp_m;
    motion_t got_m;
    got_m = '{buttons_o, delta_x_o, delta_y_o, cursor_x_o, cursor_y_o};
    if (motion_q.size() == 0) begin
      failures++;
      if (mismatches < 10) begin
        $display("unexpected beat: buttons %0d dx %0d dy %0d x %0d y %0d",
                 got_m.buttons, got_m.delta_x, got_m.delta_y, got_m.cursor_x, got_m.cursor_y);
      end
      mismatches++;
    end else begin
      exp_m = motion_q.pop_front();
      packets_seen++;
      if (got_m.buttons !== exp_m.buttons || got_m.delta_x !== exp_m.delta_x ||
          got_m.delta_y !== exp_m.delta_y || got_m.cursor_x !== exp_m.cursor_x ||
          got_m.cursor_y !== exp_m.cursor_y) begin
        failures++;
        if (mismatches < 10) begin
          $display("mismatch: expected buttons %0d dx %0d dy %0d x %0d y %0d",
                   exp_m.buttons, exp_m.delta_x, exp_m.delta_y, exp_m.cursor_x,
                   exp_m.cursor_y);
          $display("          actual   buttons %0d dx %0d dy %0d x %0d y %0d",
                   got_m.buttons, got_m.delta_x, got_m.delta_y, got_m.cursor_x,
                   got_m.cursor_y);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    motion_t m;
    in_took  <= in_valid_i && !in_stall_o;
    out_took <= out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_motion();
      if (in_valid_i && !in_stall_o) begin
        bytes_in++;
        if (decode_byte(rx_byte_i, m)) motion_q.push_back(m);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (in_wait > 0) begin
        in_valid_i <= 1'b0;
        in_wait--;
      end else if (byte_q.size() != 0) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= byte_q.pop_front();
        if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
        in_wait = in_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_took) begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      out_hold = out_burst ? 0 : $urandom_range(0, 6);
    end
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    int w_set[9]   = '{0, 1, 4096, 8191, 4097, 640, 100, 0, 1024};
    int h_set[9]   = '{0, 1, 4096, 8191, 6000, 480, 50, 0, 768};
    int drift_x[9] = '{1, -1, 1, 1, -1, 1, 0, 0, -1};
    int drift_y[9] = '{1, 1, 1, 1, -1, 1, 0, 0, -1};
    logic [7:0] directed[$];
    int n;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_SCREEN_WIDTH;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Out-of-step bytes first, then packets covering the delta extremes and every button pattern.
    directed = '{8'h00, 8'hF7,
                 8'h09, 8'h80, 8'h7F,  8'h0A, 8'h7F, 8'h80,
                 8'hFF, 8'h00, 8'h00,  8'h0C, 8'hFF, 8'h01,
                 8'h08, 8'h01, 8'hFF,  8'h0B, 8'h55, 8'hAA,
                 8'h0D, 8'hAA, 8'h55,  8'h0E, 8'h7F, 8'h80};
    foreach (directed[i]) byte_q.push_back(directed[i]);
    settings_used = 1;
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      if (p == 7) begin
        w_set[p] = $urandom_range(1, 4096);
        h_set[p] = $urandom_range(1, 4096);
      end
      write_reg(REG_SCREEN_WIDTH, CFG_W'(w_set[p]));
      write_reg(REG_SCREEN_HEIGHT, CFG_W'(h_set[p]));
      write_reg((p % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom_range(0, 8191)));
      settings_used++;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          byte_q.push_back(8'($urandom_range(0, 255)));
          n++;
        end else begin
          byte_q.push_back(8'($urandom_range(0, 255)) | 8'h08);
          byte_q.push_back(delta_byte(drift_x[p]));
          byte_q.push_back(delta_byte(-drift_y[p]));
          n += 3;
        end
      end
      wait_idle();
    end

    if (motion_q.size() != 0) begin
      failures += motion_q.size();
      $display("%0d expected packets never arrived", motion_q.size());
    end
    $display("covered %0d bytes and %0d packets over %0d screen bound settings",
             bytes_in, packets_seen, settings_used);
    $display("cursor clamped %0d times, %0d failures", clamp_hits, failures);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
